// ===== sv/qdt_pkg.sv =====
// Shared types, constants and helpers of the quoted delimited tokenizer.
// Used by the controller, the datapath, the top level and the checker.
package qdt_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int MAX_TOKENS    = 255;

  localparam int PEND_IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int TOK_CNT_W  = $clog2(MAX_TOKENS + 1);

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] REG_DELIMITER  = 2'd0;
  localparam logic [1:0] REG_TERMINATOR = 2'd1;
  localparam logic [1:0] REG_QUOTE      = 2'd2;
  localparam logic [1:0] REG_ESCAPE     = 2'd3;

  localparam logic [7:0] RST_DELIMITER  = 8'd44;
  localparam logic [7:0] RST_TERMINATOR = 8'd59;
  localparam logic [7:0] RST_QUOTE      = 8'd34;
  localparam logic [7:0] RST_ESCAPE     = 8'd92;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] token_index;
    logic       terminator_seen;
    logic       tokens_valid;
    logic       overflow;
    logic       last_of_run;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic step;       // take the accepted item
    logic emit_pend;  // release one held whitespace byte
    logic emit_held;  // release the byte that triggered the release
  } qdt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic need_release;  // current input item must first flush held whitespace
    logic rel_last;      // release index is at the last held byte
  } qdt_status_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [7:0] tok_index(logic [TOK_CNT_W-1:0] cnt);
    return 8'(cnt);
  endfunction

endpackage

// ===== sv/qdt_ctrl.sv =====
// Sequencer of the quoted delimited tokenizer: input acceptance and the
// release of held whitespace. Depends on qdt_pkg.
module qdt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qdt_pkg::qdt_status_t status_i,
  output qdt_pkg::qdt_cmd_t    cmd_o
);
  import qdt_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RELEASE = 2'd1;
  localparam logic [1:0] ST_HELD    = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE) || !status_i.out_free;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.need_release) state_d = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (status_i.out_free) begin
          cmd_o.emit_pend = 1'b1;
          if (status_i.rel_last) state_d = ST_HELD;
        end
      end
      ST_HELD: begin
        if (status_i.out_free) begin
          cmd_o.emit_held = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/qdt_dp.sv =====
// Datapath of the quoted delimited tokenizer: parse state, held whitespace
// store and output register. Depends on qdt_pkg.
module qdt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qdt_pkg::in_item_t    in_item_i,
  input  logic [7:0]           delimiter_i,
  input  logic [7:0]           terminator_i,
  input  logic [7:0]           quote_i,
  input  logic [7:0]           escape_i,
  input  qdt_pkg::qdt_cmd_t    cmd_i,
  output qdt_pkg::qdt_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qdt_pkg::out_item_t   out_item_o
);
  import qdt_pkg::*;

  logic                  in_quote_q, in_quote_d;
  logic                  escaping_q, escaping_d;
  logic                  skip_q, skip_d;
  logic                  started_q, started_d;
  logic                  finished_q, finished_d;
  logic                  ovf_q, ovf_d;
  logic [TOK_CNT_W-1:0]  tok_cnt_q, tok_cnt_d;
  logic [PEND_CNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0]            pend_q [PENDING_DEPTH];
  logic [PEND_IDX_W-1:0] idx_q;
  logic [7:0]            hold_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  // Decode of the current input item
  logic       pend_wr;
  logic       emit;
  logic       start_rel;
  out_item_t  step_item;
  logic [7:0] c;
  logic       ws;

  assign c  = in_item_i.in_byte;
  assign ws = is_ws(c);

  always_comb begin
    logic do_content;
    logic do_close;
    do_content = 1'b0;
    do_close   = 1'b0;
    in_quote_d = in_quote_q;
    escaping_d = escaping_q;
    skip_d     = skip_q;
    started_d  = started_q;
    finished_d = finished_q;
    ovf_d      = ovf_q;
    tok_cnt_d  = tok_cnt_q;
    pend_cnt_d = pend_cnt_q;
    pend_wr    = 1'b0;
    emit       = 1'b0;
    start_rel  = 1'b0;
    step_item  = '0;

    if (in_item_i.end_of_text) begin
      emit                      = 1'b1;
      step_item.kind            = KIND_SUMMARY;
      step_item.token_index     = tok_index(tok_cnt_q);
      step_item.terminator_seen = finished_q;
      step_item.tokens_valid    = !in_quote_q;
      step_item.overflow        = ovf_q;
      step_item.last_of_run     = 1'b1;
      in_quote_d = 1'b0;
      escaping_d = 1'b0;
      skip_d     = 1'b1;
      started_d  = 1'b0;
      finished_d = 1'b0;
      ovf_d      = 1'b0;
      tok_cnt_d  = '0;
      pend_cnt_d = '0;
    end else if (c != CHAR_NUL && !finished_q) begin
      if (in_quote_q) begin
        if (escaping_q) begin
          escaping_d = 1'b0;
          do_content = 1'b1;
        end else if (c == quote_i) begin
          in_quote_d = 1'b0;
        end else if (c == escape_i) begin
          escaping_d = 1'b1;
        end else begin
          do_content = 1'b1;
        end
      end else if (!(skip_q && ws)) begin
        skip_d = 1'b0;
        if (c == terminator_i) begin
          do_close   = 1'b1;
          finished_d = 1'b1;
        end else if (c == delimiter_i) begin
          do_close = 1'b1;
          if (delimiter_i == CHAR_SPACE) skip_d = 1'b1;
        end else if (c == quote_i) begin
          in_quote_d = 1'b1;
          escaping_d = 1'b0;
        end else begin
          do_content = 1'b1;
        end
      end

      if (do_content) begin
        if (ws) begin
          if (started_q) begin
            if (pend_cnt_q < PEND_CNT_W'(PENDING_DEPTH)) begin
              pend_wr    = 1'b1;
              pend_cnt_d = pend_cnt_q + PEND_CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end else begin
          started_d = 1'b1;
          if (pend_cnt_q != '0) begin
            start_rel = 1'b1;
          end else begin
            emit                  = 1'b1;
            step_item.kind        = KIND_CHAR;
            step_item.out_byte    = c;
            step_item.token_index = tok_index(tok_cnt_q);
          end
        end
      end

      if (do_close) begin
        emit                  = 1'b1;
        step_item.kind        = KIND_CLOSE;
        step_item.token_index = tok_index(tok_cnt_q);
        if (tok_cnt_q >= TOK_CNT_W'(MAX_TOKENS)) begin
          ovf_d = 1'b1;
        end else begin
          tok_cnt_d = tok_cnt_q + TOK_CNT_W'(1);
        end
        pend_cnt_d = '0;
        started_d  = 1'b0;
      end

      // flags show the state after the step
      step_item.terminator_seen = finished_d;
      step_item.tokens_valid    = !in_quote_d;
      step_item.overflow        = ovf_d;
      step_item.last_of_run     = 1'b1;
    end
  end

  // Result of a release step; the flags are already final
  out_item_t rel_item;
  always_comb begin
    rel_item                 = '0;
    rel_item.kind            = KIND_CHAR;
    rel_item.out_byte        = cmd_i.emit_held ? hold_q : pend_q[idx_q];
    rel_item.token_index     = tok_index(tok_cnt_q);
    rel_item.terminator_seen = finished_q;
    rel_item.tokens_valid    = !in_quote_q;
    rel_item.overflow        = ovf_q;
    rel_item.last_of_run     = cmd_i.emit_held;
  end

  assign status_o.out_free     = !out_valid_q || !out_stall_i;
  assign status_o.need_release = start_rel;
  assign status_o.rel_last     = (PEND_CNT_W'(idx_q) + PEND_CNT_W'(1)) == pend_cnt_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q  <= 1'b0;
      escaping_q  <= 1'b0;
      skip_q      <= 1'b1;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      ovf_q       <= 1'b0;
      tok_cnt_q   <= '0;
      pend_cnt_q  <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        in_quote_q <= in_quote_d;
        escaping_q <= escaping_d;
        skip_q     <= skip_d;
        started_q  <= started_d;
        finished_q <= finished_d;
        ovf_q      <= ovf_d;
        tok_cnt_q  <= tok_cnt_d;
        pend_cnt_q <= pend_cnt_d;
        idx_q      <= '0;
      end else if (cmd_i.emit_pend) begin
        idx_q <= idx_q + PEND_IDX_W'(1);
      end else if (cmd_i.emit_held) begin
        pend_cnt_q <= '0;
      end

      if ((cmd_i.step && emit) || cmd_i.emit_pend || cmd_i.emit_held) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && pend_wr) pend_q[pend_cnt_q[PEND_IDX_W-1:0]] <= c;
    if (cmd_i.step && start_rel) hold_q <= c;
    if (cmd_i.step && emit) begin
      out_q <= step_item;
    end else if (cmd_i.emit_pend || cmd_i.emit_held) begin
      out_q <= rel_item;
    end
  end

endmodule

// ===== sv/quoted_delimited_tokenizer.sv =====
// Quoted delimited tokenizer: top level with the configuration registers,
// the sequencer (qdt_ctrl) and the datapath (qdt_dp). Depends on qdt_pkg.
//
// Usage: text enters one byte per item on the input channel (in_valid_i /
// in_stall_o / in_item_i); an item with end_of_text set closes the text,
// yields a summary item and clears the parse state. Results leave on the
// output channel (out_valid_o / out_stall_i / out_item_o): token characters
// with their token index, one item per token close, and the summary.
// last_of_run marks the final result caused by an input item.
// Timing: a result shows on out_valid_o the cycle after its item is taken;
// held whitespace leaves in the release state, its trigger in the held state.
// Throughput: one item per cycle while the output is free; a content byte
// releasing N held whitespace bytes gives N + 1 results, one per output cycle.
// The input stalls while held whitespace drains and whenever the output
// register is full and stalled; a stalled output item holds its value.
// Reset: delimiter ',', terminator ';', quote '"', escape '\'; parse state
// empty with whitespace skipping on. No clearing pass is needed.
// Configuration: APB writes at byte addresses 0, 4, 8, 12; write only while
// the block is idle. pready is always high.
module quoted_delimited_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qdt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qdt_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qdt_pkg::*;

  logic [7:0] delim_q, term_q, quote_q, escape_q;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  qdt_cmd_t    cmd;
  qdt_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Register file: each register keeps the low byte of the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= RST_DELIMITER;
      term_q   <= RST_TERMINATOR;
      quote_q  <= RST_QUOTE;
      escape_q <= RST_ESCAPE;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DELIMITER:  delim_q  <= pwdata[7:0];
        REG_TERMINATOR: term_q   <= pwdata[7:0];
        REG_QUOTE:      quote_q  <= pwdata[7:0];
        REG_ESCAPE:     escape_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DELIMITER:  prdata = {24'd0, delim_q};
      REG_TERMINATOR: prdata = {24'd0, term_q};
      REG_QUOTE:      prdata = {24'd0, quote_q};
      REG_ESCAPE:     prdata = {24'd0, escape_q};
      default:        prdata = '0;
    endcase
  end

  // Sequencer: accepts items and paces the whitespace release
  qdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: parse state, held whitespace, output register
  qdt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_item_i    (in_item_i),
    .delimiter_i  (delim_q),
    .terminator_i (term_q),
    .quote_i      (quote_q),
    .escape_i     (escape_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== sv/qdt_checker.sv =====
// Port-level checks of the quoted delimited tokenizer, bound to the top
// level. Depends on qdt_pkg.
module qdt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input qdt_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qdt_pkg::out_item_t out_item_o
);
  import qdt_pkg::*;

  // End of text gives its summary in the very next cycle
  a_eot_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.end_of_text
      |=> out_valid_o && out_item_o.kind == KIND_SUMMARY)
    else $error("summary missing after end of text");

  // A token close is the only result of its item and carries no byte
  a_close_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_CLOSE
      |-> out_item_o.last_of_run && out_item_o.out_byte == 8'd0)
    else $error("token close not alone");

  // Summary ends the run and carries no byte
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_SUMMARY
      |-> out_item_o.last_of_run && out_item_o.out_byte == 8'd0)
    else $error("summary malformed");

  // Output register holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output changed");

endmodule

bind quoted_delimited_tokenizer qdt_checker u_qdt_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of quoted_delimited_tokenizer: feeds text bytes under
// random idling, predicts every result item and compares it field by field.
// Depends on qdt_pkg and the quoted_delimited_tokenizer top level.
module tb;
  import qdt_pkg::*;

  localparam int CLK_HALF           = 6;
  localparam int RESET_CYCLES       = 6;
  localparam int SETTLE_CYCLES      = 24;      // longest release plus margin
  localparam int HOLD_OFF_CYCLES    = 160;
  localparam int CYCLE_LIMIT        = 1000000;
  localparam int RANDOM_PER_SETTING = 11;
  localparam int N_SETTINGS         = 10;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] term;
    logic [7:0] quote;
    logic [7:0] esc;
  } char_set_t;

  // Token predictor and store of expected result items.
  class token_scoreboard;
    logic [7:0]  delim_c, term_c, quote_c, esc_c;
    bit          in_quote, escaping, skip_blank, started, finished, ovf_seen;
    int unsigned tok_count;
    logic [7:0]  held_q[$];
    out_item_t   run_q[$];
    out_item_t   want_q[$];
    int unsigned n_errors, n_inputs, n_checked, n_texts, longest_run, n_ovf_results;

    function new();
      delim_c = RST_DELIMITER;
      term_c  = RST_TERMINATOR;
      quote_c = RST_QUOTE;
      esc_c   = RST_ESCAPE;
      clear_text();
    endfunction

    function void clear_text();
      in_quote   = 1'b0;
      escaping   = 1'b0;
      skip_blank = 1'b1;
      started    = 1'b0;
      finished   = 1'b0;
      ovf_seen   = 1'b0;
      tok_count  = 0;
      held_q.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_DELIMITER:  delim_c = val;
        REG_TERMINATOR: term_c  = val;
        REG_QUOTE:      quote_c = val;
        REG_ESCAPE:     esc_c   = val;
        default: ;
      endcase
    endfunction

    function bit blank(logic [7:0] c);
      return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] b);
      out_item_t r;
      r = '0;
      r.kind        = kind;
      r.out_byte    = b;
      r.token_index = tok_count[7:0];
      run_q.push_back(r);
    endfunction

    // Trim leading whitespace, hold trailing whitespace until content follows.
    function void add_content(logic [7:0] c);
      if (blank(c)) begin
        if (!started) return;
        if (held_q.size() < PENDING_DEPTH) held_q.push_back(c);
        else ovf_seen = 1'b1;
        return;
      end
      foreach (held_q[i]) add_result(KIND_CHAR, held_q[i]);
      held_q.delete();
      add_result(KIND_CHAR, c);
      started = 1'b1;
    endfunction

    function void close_token();
      add_result(KIND_CLOSE, 8'h00);
      if (tok_count >= MAX_TOKENS) ovf_seen = 1'b1;
      else tok_count++;
      held_q.delete();
      started = 1'b0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   r;
      logic [7:0]  c;
      c = it.in_byte;
      n_inputs++;
      run_q.delete();
      if (it.end_of_text) begin
        r = '0;
        r.kind            = KIND_SUMMARY;
        r.token_index     = tok_count[7:0];
        r.terminator_seen = finished;
        r.tokens_valid    = !in_quote;
        r.overflow        = ovf_seen;
        r.last_of_run     = 1'b1;
        want_q.push_back(r);
        n_texts++;
        clear_text();
        return;
      end
      if (c == CHAR_NUL || finished) return;
      if (in_quote) begin
        if (escaping) begin
          escaping = 1'b0;
          add_content(c);
        end else if (c == quote_c) begin
          in_quote = 1'b0;
        end else if (c == esc_c) begin
          escaping = 1'b1;
        end else begin
          add_content(c);
        end
      end else begin
        if (skip_blank && blank(c)) return;
        skip_blank = 1'b0;
        if (c == term_c) begin
          close_token();
          finished = 1'b1;
        end else if (c == delim_c) begin
          close_token();
          if (delim_c == CHAR_SPACE) skip_blank = 1'b1;
        end else if (c == quote_c) begin
          in_quote = 1'b1;
          escaping = 1'b0;
        end else begin
          add_content(c);
        end
      end
      // Flags carry the state after the step, on every result of the step.
      foreach (run_q[k]) begin
        r = run_q[k];
        r.terminator_seen = finished;
        r.tokens_valid    = !in_quote;
        r.overflow        = ovf_seen;
        r.last_of_run     = (k == run_q.size() - 1);
        want_q.push_back(r);
      end
      if (run_q.size() > longest_run) longest_run = run_q.size();
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        $error("result with nothing expected: kind %0d byte %0h index %0d",
               got.kind, got.out_byte, got.token_index);
        n_errors++;
        return;
      end
      want = want_q.pop_front();
      n_checked++;
      if (got.overflow === 1'b1) n_ovf_results++;
      compare("kind", 8'(want.kind), 8'(got.kind));
      compare("out_byte", want.out_byte, got.out_byte);
      compare("token_index", want.token_index, got.token_index);
      compare("terminator_seen", 8'(want.terminator_seen), 8'(got.terminator_seen));
      compare("tokens_valid", 8'(want.tokens_valid), 8'(got.tokens_valid));
      compare("overflow", 8'(want.overflow), 8'(got.overflow));
      compare("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction

    function int outstanding();
      return want_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  token_scoreboard sb;
  in_item_t        feed_q[$];       // text items waiting to be offered
  int              tx_quiet = 0;    // remaining items of a no-idle stretch
  int              rx_quiet = 0;
  bit              hold_off_req = 1'b0;
  int unsigned     cycles = 0;
  int unsigned     n_settings = 0;

  quoted_delimited_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL quoted_delimited_tokenizer");
      $finish;
    end
  end

  // Idle draw: mostly a random idle gap, with stretches of back-to-back items.
  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------------------
  // Text building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.in_byte     = b;
    it.end_of_text = 1'b0;
    feed_q.push_back(it);
  endfunction

  // The byte riding on an end-of-text item is ignored; randomize it anyway.
  function automatic void push_eot(logic [7:0] junk);
    in_item_t it;
    it.in_byte     = junk;
    it.end_of_text = 1'b1;
    feed_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_blank();
    int v;
    v = $urandom_range(8, 13);
    return (v == 8) ? CHAR_SPACE : 8'(v);
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  // Noise leans on the special bytes of the current setting.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 9))
      0:       return sb.delim_c;
      1:       return sb.term_c;
      2:       return sb.quote_c;
      3:       return sb.esc_c;
      4:       return pick_blank();
      5:       return CHAR_NUL;
      6, 7:    return pick_letter();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_cfg_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(33, 126));
      1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2:       return pick_blank();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short whitespace runs; now and then one long enough to fill
  // the held-whitespace store and spill over it.
  function automatic int blank_run_len();
    if ($urandom_range(0, 5) == 0) return $urandom_range(14, 20);
    return $urandom_range(0, 2);
  endfunction

  function automatic void push_blanks(int n);
    repeat (n) push_byte(pick_blank());
  endfunction

  // Quoted section with delimiters, terminators, whitespace and escapes as
  // content; now and then left open.
  function automatic void push_quoted();
    push_byte(sb.quote_c);
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 7))
        0: begin
          push_byte(sb.esc_c);
          push_byte(8'($urandom_range(0, 255)));
        end
        1:       push_byte(sb.delim_c);
        2:       push_byte(sb.term_c);
        3:       push_byte(pick_blank());
        default: push_byte(pick_letter());
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_byte(sb.quote_c);
  endfunction

  // Mostly well-formed texts with random content, the rest noise.
  function automatic void gen_texts(int n_target);
    int stop_at;
    int n_tok;
    int n_part;
    stop_at = feed_q.size() + n_target;
    while (feed_q.size() < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 12)) push_byte(pick_noise());
        if ($urandom_range(0, 1) == 0) push_eot(8'($urandom_range(0, 255)));
      end else begin
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++) begin
          push_blanks($urandom_range(0, 2));
          n_part = $urandom_range(1, 3);
          for (int p = 0; p < n_part; p++) begin
            if (p > 0) push_blanks(blank_run_len());
            if ($urandom_range(0, 2) == 0) push_quoted();
            else repeat ($urandom_range(1, 4)) push_byte(pick_letter());
          end
          push_blanks(blank_run_len());
          if (t < n_tok - 1) begin
            push_byte(sb.delim_c);
          end else begin
            // last token: terminator, delimiter, or left unfinished
            case ($urandom_range(0, 6))
              0:       ;
              1:       push_byte(sb.delim_c);
              default: push_byte(sb.term_c);
            endcase
          end
        end
        repeat ($urandom_range(0, 2)) push_byte(pick_noise());
        push_eot(8'($urandom_range(0, 255)));
      end
    end
    // Cut the last text to the item budget and close it with end of text.
    while (feed_q.size() >= stop_at) void'(feed_q.pop_back());
    push_eot(8'($urandom_range(0, 255)));
  endfunction

  // Short hand-written text under the reset setting.
  function automatic void load_directed();
    push_byte(CHAR_SPACE);     // skipped at the start of the text
    push_byte(CHAR_TAB);
    push_byte("a");
    push_byte(CHAR_NUL);       // zero byte: no result
    push_byte(CHAR_SPACE);     // held, then released ahead of the next byte
    push_byte("b");
    push_byte(CHAR_CR);        // held, then dropped by the close
    push_byte(sb.delim_c);
    push_byte(sb.quote_c);
    push_byte(CHAR_SPACE);     // quoted but still leading, so trimmed
    push_byte(sb.delim_c);     // delimiter as quoted content
    push_byte(sb.esc_c);
    push_byte(sb.quote_c);     // escaped quote is content
    push_byte(sb.esc_c);
    push_byte(sb.esc_c);       // escaped escape is content
    push_byte(sb.quote_c);
    push_byte(8'hFF);
    push_byte(sb.term_c);
    push_byte("z");            // ignored after the terminator
    push_eot(8'h00);
    push_byte(sb.quote_c);     // quote left open, token unfinished
    push_byte("q");
    push_eot(8'hFF);
    push_byte("k");            // unfinished token, not counted
    push_eot(8'h5A);
    push_byte("a");            // a full store of held spaces, one more overflows
    repeat (PENDING_DEPTH + 1) push_byte(CHAR_SPACE);
    push_byte("b");            // longest release: every held byte, then "b"
    push_eot(8'h00);
  endfunction

  function automatic char_set_t setting_for(int n);
    char_set_t s;
    case (n)
      0: s = '{RST_DELIMITER, RST_TERMINATOR, RST_QUOTE, RST_ESCAPE};
      1: s = '{CHAR_SPACE, RST_TERMINATOR, 8'h27, RST_ESCAPE};  // space splits
      2: s = '{8'hFF, 8'h00, 8'hFE, 8'h01};
      3: s = '{8'h00, 8'hFF, 8'h01, 8'hFE};
      // terminator wins over delimiter, quote wins over escape
      4: s = '{RST_DELIMITER, RST_DELIMITER, RST_QUOTE, RST_QUOTE};
      // delimiter wins over quote; whitespace escape
      5: s = '{RST_QUOTE, RST_TERMINATOR, RST_QUOTE, CHAR_TAB};
      // whitespace as control bytes meets the skipping rule
      6: s = '{CHAR_TAB, 8'h0A, CHAR_SPACE, CHAR_CR};
      default: s = '{pick_cfg_char(), pick_cfg_char(), pick_cfg_char(), pick_cfg_char()};
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  // Setup then access; psel stays up so that accesses run back to back.
  task automatic reg_access(logic wr, logic [1:0] idx, logic [7:0] val,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [7:0] val);
    logic [31:0] rd;
    reg_access(1'b1, idx, val, rd);
    sb.set_reg(idx, val);
  endtask

  task automatic reg_check(logic [1:0] idx, string name, logic [7:0] want);
    logic [31:0] rd;
    reg_access(1'b0, idx, 8'h00, rd);
    if (rd !== {24'h0, want}) begin
      $error("%s: expected %0h, got %0h", name, want, rd);
      sb.n_errors++;
    end
  endtask

  task automatic apply_setting(char_set_t s);
    reg_write(REG_DELIMITER, s.delim);
    reg_write(REG_TERMINATOR, s.term);
    reg_write(REG_QUOTE, s.quote);
    reg_write(REG_ESCAPE, s.esc);
    reg_check(REG_DELIMITER, "delimiter_char", s.delim);
    reg_check(REG_TERMINATOR, "terminator_char", s.term);
    reg_check(REG_QUOTE, "quote_char", s.quote);
    reg_check(REG_ESCAPE, "escape_char", s.esc);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: offer every queued item, note it with the predictor when taken
  // ---------------------------------------------------------------------------
  task automatic send_feed();
    int       gap;
    in_item_t it;
    while (feed_q.size() > 0) begin
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      it = feed_q.pop_front();
      // valid stays high across back-to-back items: one assignment per edge
      in_item_i  <= it;
      in_valid_i <= 1'b1;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      sb.note_input(it);
    end
    in_valid_i <= 1'b0;
  endtask

  // Wait out every expected result, then the release of any item still
  // in flight that causes none.
  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per item, plus a long hold-off on request so the
  // output register fills and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else begin
        gap = draw_gap(rx_quiet);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(out_item_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    char_set_t cs;
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values read back before anything is written.
    reg_check(REG_DELIMITER, "delimiter_char", RST_DELIMITER);
    reg_check(REG_TERMINATOR, "terminator_char", RST_TERMINATOR);
    reg_check(REG_QUOTE, "quote_char", RST_QUOTE);
    reg_check(REG_ESCAPE, "escape_char", RST_ESCAPE);
    psel    <= 1'b0;
    penable <= 1'b0;

    hold_off_req = 1'b1;
    load_directed();
    send_feed();
    settle();

    // One setting per phase; registers change only once the block is idle.
    for (int n = 0; n < N_SETTINGS; n++) begin
      cs = setting_for(n);
      apply_setting(cs);
      if (n == 0) hold_off_req = 1'b1;
      gen_texts(RANDOM_PER_SETTING);
      send_feed();
      settle();
    end

    $display("Run covered %0d texts, %0d accepted items and %0d checked results over %0d settings;",
             sb.n_texts, sb.n_inputs, sb.n_checked, n_settings);
    $display("longest burst %0d results, %0d results with overflow set, %0d errors.",
             sb.longest_run, sb.n_ovf_results, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("PASS quoted_delimited_tokenizer");
    end else begin
      $display("FAIL quoted_delimited_tokenizer");
    end
    $finish;
  end

endmodule
